// File: rtl/fdcds_pkg.sv
package fdcds_pkg;

	localparam int DIGIT_COUNT_DEF = 4;
	localparam int BUTTON_MAX      = 4;
	localparam int SEG_W           = 8;
	localparam int DIGIT_W         = 4;
	localparam int ENABLE_W        = 4;
	localparam int DEBOUNCE_W      = 8;
	localparam int BIT_CNT_W       = 3;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QPTR_W          = 1;
	localparam int QCNT_W          = 2;
	localparam int S_TDATA_W       = 8;
	localparam int M_TDATA_W       = 16;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd5;
	localparam logic [DIGIT_W-1:0]    DIGIT_MAX      = 4'd9;
	localparam logic                  MODE_SAMPLE    = 1'b0;
	localparam logic                  MODE_SCAN      = 1'b1;

	// One scan job waiting between the front and the serializer.
	typedef struct packed {
		logic [SEG_W-1:0]    seg;
		logic [ENABLE_W-1:0] enable;
	} scan_job_t;

	// Queue handshake between front and back.
	typedef struct packed {
		logic      valid;
		scan_job_t job;
	} queue_out_t;

	function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] value);
		logic [SEG_W-1:0] pat;
		case (value)
			4'd0:    pat = 8'hFC;
			4'd1:    pat = 8'h60;
			4'd2:    pat = 8'hDA;
			4'd3:    pat = 8'hF2;
			4'd4:    pat = 8'h66;
			4'd5:    pat = 8'hB6;
			4'd6:    pat = 8'hBE;
			4'd7:    pat = 8'hE0;
			4'd8:    pat = 8'hFE;
			4'd9:    pat = 8'hF6;
			default: pat = 8'h00;
		endcase
		return pat;
	endfunction

endpackage

// File: rtl/four_digit_counter_display_scanner_unit.sv
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  tuser = mode, tdata[3:0] = buttons
// m_       out  m_tvalid/m_tready  tdata = serial_bit, digit_enable, segments; tlast = latch
// cfg_     in   cfg_we             cfg_wdata = debounce_samples
//
// A button sample gives no transfer. A scan tick gives eight bits on the output
// side: the serializer shifts one bit per cycle while m_tready does not stall it.
// The input side takes a transfer every cycle while the two-entry scan queue
// has room, so up to two ticks may wait behind the one being shifted.
// Reset clears digits, scan position, debounce state and the queue.
module four_digit_counter_display_scanner_unit #(
	parameter int DIGIT_COUNT = fdcds_pkg::DIGIT_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [fdcds_pkg::S_TDATA_W-1:0]  s_tdata,   // [3:0] buttons, [7:4] zero
	input  logic                             s_tuser,   // [0] mode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [fdcds_pkg::M_TDATA_W-1:0]  m_tdata,   // [0] serial_bit, [4:1] digit_enable,
	                                                    // [12:5] segments, [15:13] zero
	output logic                             m_tlast,   // latch
	input  logic                             cfg_we,
	input  logic [fdcds_pkg::DEBOUNCE_W-1:0] cfg_wdata
);
	import fdcds_pkg::*;

	logic       q_full, push, pop, in_accept;
	scan_job_t  push_job;
	queue_out_t head;

	// Hold off input only while the scan queue is full.
	assign s_tready  = !q_full;
	assign in_accept = s_tvalid && s_tready;

	// Front: debounce buttons, keep digits, capture the pattern for each tick.
	fdcds_front #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_accept(in_accept),
		.mode     (s_tuser),
		.buttons  (s_tdata[BUTTON_MAX-1:0]),
		.push     (push),
		.push_job (push_job)
	);

	// Queue: decouple tick capture from serial shifting.
	fdcds_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (pop),
		.head    (head)
	);

	// Back: shift each pattern out MSB first, latch and enable on the last bit.
	fdcds_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

// File: rtl/fdcds_front.sv
module fdcds_front #(
	parameter int DIGIT_COUNT = fdcds_pkg::DIGIT_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fdcds_pkg::DEBOUNCE_W-1:0] cfg_wdata,
	input  logic                             in_accept,
	input  logic                             mode,
	input  logic [fdcds_pkg::BUTTON_MAX-1:0] buttons,
	output logic                             push,
	output fdcds_pkg::scan_job_t             push_job
);
	import fdcds_pkg::*;

	localparam int POS_W     = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int BTN_COUNT = (DIGIT_COUNT < BUTTON_MAX) ? DIGIT_COUNT : BUTTON_MAX;

	logic [DEBOUNCE_W-1:0] debounce_q;
	logic [DIGIT_W-1:0]    digit_q [DIGIT_COUNT];
	logic [DIGIT_W-1:0]    digit_n [DIGIT_COUNT];
	logic [POS_W-1:0]      pos_q;
	logic [BUTTON_MAX-1:0] prev_q;
	logic [BTN_COUNT-1:0]  pend_q, pend_n;
	logic [DEBOUNCE_W-1:0] cd_q [BTN_COUNT];
	logic [DEBOUNCE_W-1:0] cd_n [BTN_COUNT];
	logic                  sample;
	logic [ENABLE_W-1:0]   enable;

	assign sample = in_accept && (mode == MODE_SAMPLE);
	assign push   = in_accept && (mode == MODE_SCAN);

	always_comb begin
		enable = '0;
		for (int i = 0; i < BTN_COUNT; i++) begin
			enable[i] = (pos_q == POS_W'(i));
		end
		push_job.seg    = seg_pattern(digit_q[pos_q]);
		push_job.enable = enable;
	end

	// Debounce lanes: one per digit that owns a button.
	always_comb begin
		for (int d = 0; d < DIGIT_COUNT; d++) begin
			digit_n[d] = digit_q[d];
		end
		pend_n = pend_q;
		for (int i = 0; i < BTN_COUNT; i++) begin
			cd_n[i] = cd_q[i];
			if (pend_q[i]) begin
				if (cd_q[i] != '0) begin
					cd_n[i] = cd_q[i] - 1'b1;
				end
				if (cd_n[i] == '0) begin
					pend_n[i] = 1'b0;
					if (!buttons[i]) begin
						digit_n[i] = (digit_q[i] >= DIGIT_MAX) ? '0 : digit_q[i] + 1'b1;
					end
				end
			end else if (prev_q[i] && !buttons[i]) begin
				cd_n[i] = debounce_q;
				if (debounce_q == '0) begin
					digit_n[i] = (digit_q[i] >= DIGIT_MAX) ? '0 : digit_q[i] + 1'b1;
				end else begin
					pend_n[i] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			pos_q      <= '0;
			prev_q     <= '1;
			pend_q     <= '0;
			for (int d = 0; d < DIGIT_COUNT; d++) begin
				digit_q[d] <= '0;
			end
			for (int i = 0; i < BTN_COUNT; i++) begin
				cd_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				debounce_q <= cfg_wdata;
			end
			if (sample) begin
				prev_q <= buttons;
				pend_q <= pend_n;
				for (int d = 0; d < DIGIT_COUNT; d++) begin
					digit_q[d] <= digit_n[d];
				end
				for (int i = 0; i < BTN_COUNT; i++) begin
					cd_q[i] <= cd_n[i];
				end
			end
			if (push) begin
				pos_q <= (pos_q == POS_W'(DIGIT_COUNT - 1)) ? '0 : pos_q + 1'b1;
			end
		end
	end

endmodule

// File: rtl/fdcds_fifo.sv
module fdcds_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  fdcds_pkg::scan_job_t  push_job,
	output logic                  full,
	input  logic                  pop,
	output fdcds_pkg::queue_out_t head
);
	import fdcds_pkg::*;

	scan_job_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q, rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.job   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/fdcds_back.sv
module fdcds_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fdcds_pkg::queue_out_t            head,
	output logic                             pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [fdcds_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                             m_tlast
);
	import fdcds_pkg::*;

	scan_job_t            job_q, cur;
	logic                 busy_q;
	logic [BIT_CNT_W-1:0] cnt_q, cnt;
	logic                 load_out, emit, last;
	logic                 out_valid_q, out_last_q;
	logic [M_TDATA_W-1:0] out_data_q;

	assign load_out = !out_valid_q || m_tready;
	assign emit     = load_out && (busy_q || head.valid);
	assign pop      = emit && !busy_q;
	assign cur      = busy_q ? job_q : head.job;
	assign cnt      = busy_q ? cnt_q : '0;
	assign last     = (cnt == '1);

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head.job;
		end
		if (emit) begin
			out_data_q <= {3'b000, cur.seg, (last ? cur.enable : '0), cur.seg[~cnt]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (emit) begin
				busy_q     <= !last;
				cnt_q      <= cnt + 1'b1;
				out_last_q <= last;
			end
			if (load_out) begin
				out_valid_q <= emit;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// File: bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fdcds_pkg::*;

	localparam int CYCLE_LIMIT   = 100000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASES        = 5;

	// Seven-segment glyphs for 0..9, segment a in the MSB.
	localparam logic [SEG_W-1:0] GLYPH [10] = '{
		8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
	};

	// Phase plan: hold-off setting, sender gap and receiver stall (percent), random items.
	// The first phase runs on the reset hold-off; the longest hold-off comes last so that
	// its long countdowns cannot block presses in later phases.
	localparam int HOLD_PLAN  [PHASES] = '{5, 0, 2, 1, 255};
	localparam int GAP_PLAN   [PHASES] = '{0, 61, 0, 21, 21};
	localparam int STALL_PLAN [PHASES] = '{0, 0, 61, 21, 21};
	localparam int ITEM_PLAN  [PHASES] = '{15, 20, 20, 20, 10};

	// One serial bit of a scan, as it appears on the output stream.
	typedef struct packed {
		logic                serial;
		logic                latch;
		logic [ENABLE_W-1:0] enable;
		logic [SEG_W-1:0]    segments;
	} digit_bit_t;

	// Mirror of the counter and debounce state plus the queue of serial bits still due.
	class display_scoreboard;
		logic [DEBOUNCE_W-1:0] hold_off;
		logic [DIGIT_W-1:0]    digit [DIGIT_COUNT_DEF];
		logic [DEBOUNCE_W-1:0] countdown [BUTTON_MAX];
		logic [BUTTON_MAX-1:0] last_levels;
		logic [BUTTON_MAX-1:0] armed;
		int                    position;
		digit_bit_t            bits_due [$];
		int                    errors;
		int                    bits_seen;
		int                    ticks;
		int                    samples;
		int                    bumps;

		function new();
			hold_off    = DEBOUNCE_RESET;
			last_levels = '1;
			armed       = '0;
			position    = 0;
			errors      = 0;
			bits_seen   = 0;
			ticks       = 0;
			samples     = 0;
			bumps       = 0;
			foreach (digit[i]) digit[i] = '0;
			foreach (countdown[i]) countdown[i] = '0;
		endfunction

		function int waiting();
			return bits_due.size();
		endfunction

		function void advance_digit(int i);
			digit[i] = (digit[i] >= DIGIT_MAX) ? '0 : digit[i] + 1'b1;
			bumps++;
		endfunction

		// Debounce every button, then remember this sample's levels.
		function void sample_buttons(logic [BUTTON_MAX-1:0] levels);
			for (int i = 0; i < BUTTON_MAX && i < DIGIT_COUNT_DEF; i++) begin
				if (armed[i]) begin
					if (countdown[i] != 0) countdown[i]--;
					if (countdown[i] == 0) begin
						armed[i] = 1'b0;
						if (!levels[i]) advance_digit(i);
					end
				end else if (last_levels[i] && !levels[i]) begin
					countdown[i] = hold_off;
					if (hold_off == 0) advance_digit(i);
					else armed[i] = 1'b1;
				end
			end
			last_levels = levels;
		endfunction

		// Queue the eight bits of the digit under the scan position, then advance it.
		function void scan_digit();
			logic [SEG_W-1:0]    seg;
			logic [ENABLE_W-1:0] enable;
			digit_bit_t          entry;
			seg    = (digit[position] <= DIGIT_MAX) ? GLYPH[digit[position]] : '0;
			enable = '0;
			enable[position] = 1'b1;
			for (int k = 0; k < SEG_W; k++) begin
				entry.serial   = seg[SEG_W-1-k];
				entry.latch    = (k == SEG_W - 1);
				entry.enable   = (k == SEG_W - 1) ? enable : '0;
				entry.segments = seg;
				bits_due.push_back(entry);
			end
			position = (position + 1) % DIGIT_COUNT_DEF;
		endfunction

		function void record_input(logic mode, logic [BUTTON_MAX-1:0] levels);
			if (mode == MODE_SCAN) begin
				ticks++;
				scan_digit();
			end else begin
				samples++;
				sample_buttons(levels);
			end
		endfunction

		function void flag(string field, logic [M_TDATA_W-1:0] want, logic [M_TDATA_W-1:0] got);
			errors++;
			$display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
		endfunction

		function void check_digit_bit(logic [M_TDATA_W-1:0] data, logic last);
			digit_bit_t got;
			digit_bit_t want;
			got.serial   = data[0];
			got.enable   = data[4:1];
			got.segments = data[12:5];
			got.latch    = last;
			bits_seen++;
			if (bits_due.size() == 0) begin
				flag("unexpected transfer, tdata", '0, data);
				return;
			end
			want = bits_due.pop_front();
			if (got.serial !== want.serial) flag("serial_bit", want.serial, got.serial);
			if (got.latch !== want.latch) flag("latch", want.latch, got.latch);
			if (got.enable !== want.enable) flag("digit_enable", want.enable, got.enable);
			if (got.segments !== want.segments) flag("segments", want.segments, got.segments);
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tlast;
	logic                   cfg_we    = 1'b0;
	logic [DEBOUNCE_W-1:0]  cfg_wdata = '0;

	int send_gap_pct = 0;
	int stall_pct    = 0;
	int cycle_count  = 0;

	display_scoreboard scoreboard = new();

	four_digit_counter_display_scanner_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Receiver: drop ready at random for the current stall rate, one decision per cycle.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Observe both streams at the rising edge. Note the accepted input before checking
	// the result of the same edge, so a fall-through path cannot race the prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				scoreboard.record_input(s_tuser, s_tdata[BUTTON_MAX-1:0]);
			if (m_tvalid && m_tready)
				scoreboard.check_digit_bit(m_tdata, m_tlast);
		end
	end

	// Watchdog: end the run if the block stops moving.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d serial bits still due",
				cycle_count, scoreboard.waiting());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Present one item and hold it until the transfer completes. Valid is left high;
	// the next call or the idle step decides its level at the following falling edge.
	task automatic send_item(input logic mode, input logic [BUTTON_MAX-1:0] levels);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {{(S_TDATA_W - BUTTON_MAX){1'b0}}, levels};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and wait until every scan bit has come out and the block has settled.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (scoreboard.waiting() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_hold_off(input logic [DEBOUNCE_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		scoreboard.hold_off = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly press sequences: a falling edge on a set of buttons, held long enough to
	// confirm, with scan ticks mixed in and a release at the end. Some holds are cut
	// short or run long, and some items are plain noise.
	task automatic random_traffic(input int count);
		int                    sent;
		int                    hold;
		logic [BUTTON_MAX-1:0] mask;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(9))
				0, 1: begin
					send_item(MODE_SCAN, BUTTON_MAX'($urandom));
					sent++;
				end
				2: begin
					send_item(MODE_SAMPLE, BUTTON_MAX'($urandom));
					sent++;
				end
				default: begin
					mask = BUTTON_MAX'($urandom_range(15) | $urandom_range(15));
					hold = int'(scoreboard.hold_off) + 1;
					if ($urandom_range(3) == 0) hold = $urandom_range(1, hold + 1);
					if (hold > 8) hold = $urandom_range(1, 8);
					for (int n = 0; n < hold; n++) begin
						send_item(MODE_SAMPLE, ~mask);
						sent++;
						if ($urandom_range(99) < 30) begin
							send_item(MODE_SCAN, BUTTON_MAX'($urandom));
							sent++;
						end
					end
					send_item(MODE_SAMPLE, '1);
					sent++;
				end
			endcase
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			send_gap_pct = GAP_PLAN[p];
			stall_pct    = STALL_PLAN[p];
			if (p > 0) begin
				drain();
				write_hold_off(DEBOUNCE_W'(HOLD_PLAN[p]));
			end
			case (p)
				0: begin
					// Reset hold-off: show a zero, press all four, bounce high and low
					// again while pending, then confirm on the fifth low sample.
					send_item(MODE_SCAN, '1);
					send_item(MODE_SAMPLE, '0);
					send_item(MODE_SAMPLE, '1);
					repeat (4) send_item(MODE_SAMPLE, '0);
					send_item(MODE_SAMPLE, '1);
					// Scan the rest of the digits and wrap back to the first.
					repeat (4) send_item(MODE_SCAN, '0);
				end
				1: begin
					// Zero hold-off: an edge counts on the very sample it appears.
					send_item(MODE_SAMPLE, 4'b1110);
					send_item(MODE_SAMPLE, '0);
					send_item(MODE_SAMPLE, '1);
					send_item(MODE_SCAN, '1);
				end
				PHASES - 1: begin
					// Longest hold-off: arm every button with a full countdown.
					send_item(MODE_SAMPLE, '0);
					send_item(MODE_SAMPLE, '1);
				end
				default: ;
			endcase
			random_traffic(ITEM_PLAN[p]);
		end

		drain();
		$display("Run covered %0d scan ticks and %0d button samples (%0d digit increments)",
			scoreboard.ticks, scoreboard.samples, scoreboard.bumps);
		$display("over %0d hold-off settings; %0d serial bits checked, %0d mismatches.",
			PHASES, scoreboard.bits_seen, scoreboard.errors);
		if (scoreboard.errors == 0 && scoreboard.waiting() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/fdcds_pkg.sv
rtl/fdcds_front.sv
rtl/fdcds_fifo.sv
rtl/fdcds_back.sv
rtl/four_digit_counter_display_scanner_unit.sv
bench/tb.sv
